// ----- design/sactl_pkg.sv -----
`timescale 1ns / 1ps

package sactl_pkg;

	localparam int MAX_WAYS     = 8;
	localparam int WAY_W        = 3;
	localparam int RANK_W       = 3;
	localparam int TAG_W        = 32;
	localparam int ADDR_W       = 32;
	localparam int CNT_W        = 32;
	localparam int LFSR_W       = 16;
	localparam int DEF_MAX_SETS = 64;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam int S_DATA_W   = 32;
	localparam int M_DATA_W   = 72;

	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WAYS_LOG2,
		REG_OFFSET_WIDTH,
		REG_INDEX_WIDTH,
		REG_RANDOM_REPLACE
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic clear_wr;
		logic accept;
		logic compare;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
	} status_t;

	typedef struct packed {
		logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
		logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
		logic [MAX_WAYS-1:0]             valid;
	} row_t;

	localparam int ROW_W = $bits(row_t);

endpackage

// ----- design/set_assoc_cache_tag_lookup.sv -----
`timescale 1ns / 1ps

// Tag and replacement side of a set-associative cache (no data array).
// Configuration: cfg_we / cfg_index / cfg_data write one register per cycle:
//   0 ways_log2, 1 offset_width, 2 index_width, 3 random_replace.
// Input stream s_*: one request is a 32-bit byte address.
// Output stream m_*: hit flag, way hit or filled, hit and miss totals.
// Steps: in IDLE a request is accepted and its set row is read from the
// single-port tag RAM, in CMP the row is compared across all ways, then
// in UPD it is written back (not on a hit with random replacement) and
// the result registered. No request is taken until the last leaves UPD.
// Reset: a clearing pass writes every set row of the tag RAM with
// s_tready low; configuration writes are taken meanwhile.
// Stall: a result waits in the output register while m_tready is low; the
// next request is still accepted and processed up to its write-back, where
// it holds until the output register frees.
module set_assoc_cache_tag_lookup #(
	parameter int MAX_SETS = sactl_pkg::DEF_MAX_SETS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sactl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sactl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [sactl_pkg::S_DATA_W-1:0]   s_tdata,  // address[31:0]
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [sactl_pkg::M_DATA_W-1:0]   m_tdata   // hit, way_used[2:0], hit_total[31:0],
	                                                   // miss_total[31:0], zero pad
);

	localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

	sactl_pkg::cmd_t    cmd;
	sactl_pkg::status_t status;
	logic               ram_re;
	logic               ram_we;
	logic [SET_W-1:0]   ram_addr;
	sactl_pkg::row_t    ram_wdata;
	sactl_pkg::row_t    ram_rdata;

	sactl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sactl_dpath #(
		.MAX_SETS (MAX_SETS),
		.SET_W    (SET_W)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tdata   (m_tdata),
		.ram_re    (ram_re),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata)
	);

	sactl_ram #(
		.WIDTH (sactl_pkg::ROW_W),
		.DEPTH (MAX_SETS),
		.AW    (SET_W)
	) u_ram (
		.clk   (clk),
		.re    (ram_re),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

endmodule

// ----- design/sactl_ram.sv -----
`timescale 1ns / 1ps

module sactl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             re,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/sactl_ctrl.sv -----
`timescale 1ns / 1ps

module sactl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  sactl_pkg::status_t status,
	output sactl_pkg::cmd_t    cmd
);

	sactl_pkg::state_t state_q, state_nx;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sactl_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			sactl_pkg::ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (status.clear_done) begin
					state_nx = sactl_pkg::ST_IDLE;
				end
			end
			sactl_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_nx   = sactl_pkg::ST_CMP;
				end
			end
			sactl_pkg::ST_CMP: begin
				cmd.compare = 1'b1;
				state_nx    = sactl_pkg::ST_UPD;
			end
			sactl_pkg::ST_UPD: begin
				// hold until the result register is free
				if (!out_valid_q || m_tready) begin
					cmd.update = 1'b1;
					state_nx   = sactl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = sactl_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.update) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

// ----- design/sactl_dpath.sv -----
`timescale 1ns / 1ps

module sactl_dpath #(
	parameter int MAX_SETS = sactl_pkg::DEF_MAX_SETS,
	parameter int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sactl_pkg::cmd_t                  cmd,
	output sactl_pkg::status_t               status,
	input  logic                             cfg_we,
	input  logic [sactl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sactl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [sactl_pkg::S_DATA_W-1:0]   s_tdata,
	output logic [sactl_pkg::M_DATA_W-1:0]   m_tdata,
	output logic                             ram_re,
	output logic                             ram_we,
	output logic [SET_W-1:0]                 ram_addr,
	output sactl_pkg::row_t                  ram_wdata,
	input  sactl_pkg::row_t                  ram_rdata
);

	localparam int IDX_MAX = $clog2(MAX_SETS + 1) - 1;
	localparam int WAY_W   = sactl_pkg::WAY_W;
	localparam int RANK_W  = sactl_pkg::RANK_W;
	localparam int NW      = sactl_pkg::MAX_WAYS;
	localparam int LW      = sactl_pkg::LFSR_W;
	localparam int CW      = sactl_pkg::CNT_W;

	logic [1:0] ways_log2_q;
	logic [3:0] offset_width_q;
	logic [2:0] index_width_q;
	logic       random_q;

	logic [2:0]                      ib_eff;
	logic [sactl_pkg::ADDR_W-1:0]    set_full;
	logic [sactl_pkg::TAG_W-1:0]     tag_in;
	logic [SET_W-1:0]                set_q;
	logic [SET_W-1:0]                clr_cnt_q;
	logic [sactl_pkg::TAG_W-1:0]     tag_q;
	logic [WAY_W:0]                  ways;

	logic [NW-1:0]    match;
	logic [NW-1:0]    inv;
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] inv_way;
	logic [WAY_W-1:0] lru_way;

	logic             hit_q;
	logic             found_q;
	logic [WAY_W-1:0] hit_way_q;
	logic [WAY_W-1:0] inv_way_q;
	logic [WAY_W-1:0] lru_way_q;

	logic [LW-1:0]    lfsr_q;
	logic [LW-1:0]    lfsr_nx;
	logic [WAY_W-1:0] rnd_way;
	logic [WAY_W-1:0] victim;
	logic             do_touch;
	logic [RANK_W:0]  old_rank;
	sactl_pkg::row_t  new_row;

	logic [CW-1:0] hits_q;
	logic [CW-1:0] misses_q;
	logic [CW-1:0] hits_nx;
	logic [CW-1:0] misses_nx;
	logic [sactl_pkg::M_DATA_W-1:0] out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_log2_q    <= 2'd0;
			offset_width_q <= 4'd2;
			index_width_q  <= 3'd4;
			random_q       <= 1'b0;
		end else if (cfg_we) begin
			unique case (sactl_pkg::cfg_reg_t'(cfg_index))
				sactl_pkg::REG_WAYS_LOG2:      ways_log2_q    <= cfg_data[1:0];
				sactl_pkg::REG_OFFSET_WIDTH:   offset_width_q <= cfg_data[3:0];
				sactl_pkg::REG_INDEX_WIDTH:    index_width_q  <= cfg_data[2:0];
				sactl_pkg::REG_RANDOM_REPLACE: random_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(index_width_q) > IDX_MAX) begin
			ib_eff = 3'(IDX_MAX);
		end else begin
			ib_eff = index_width_q;
		end
		set_full = (s_tdata >> offset_width_q) & ((32'd1 << ib_eff) - 32'd1);
		tag_in   = s_tdata >> (5'(offset_width_q) + 5'(ib_eff));
		ways     = (WAY_W + 1)'(1) << ways_log2_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			set_q <= set_full[SET_W-1:0];
			tag_q <= tag_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_cnt_q <= clr_cnt_q + SET_W'(1);
		end
	end

	assign status.clear_done = (clr_cnt_q == SET_W'(MAX_SETS - 1));

	always_comb begin
		match   = '0;
		inv     = '0;
		hit_way = '0;
		inv_way = '0;
		lru_way = '0;
		for (int w = 0; w < NW; w++) begin
			if ((WAY_W + 1)'(w) < ways) begin
				match[w] = ram_rdata.valid[w] && (ram_rdata.tag[w] == tag_q);
				inv[w]   = !ram_rdata.valid[w];
			end
		end
		for (int w = NW - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = WAY_W'(w);
			end
			if (inv[w]) begin
				inv_way = WAY_W'(w);
			end
		end
		for (int w = 1; w < NW; w++) begin
			if ((WAY_W + 1)'(w) < ways && ram_rdata.rank[w] > ram_rdata.rank[lru_way]) begin
				lru_way = WAY_W'(w);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			hit_q     <= |match;
			found_q   <= |inv;
			hit_way_q <= hit_way;
			inv_way_q <= inv_way;
			lru_way_q <= lru_way;
		end
	end

	always_comb begin
		lfsr_nx = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[LW-1:1]};
		rnd_way = lfsr_nx[WAY_W-1:0] & WAY_W'(ways - (WAY_W + 1)'(1));
		if (hit_q) begin
			victim = hit_way_q;
		end else if (found_q) begin
			victim = inv_way_q;
		end else if (random_q) begin
			victim = rnd_way;
		end else begin
			victim = lru_way_q;
		end
		do_touch = !hit_q || !random_q;
		if (ram_rdata.valid[victim]) begin
			old_rank = {1'b0, ram_rdata.rank[victim]};
		end else begin
			old_rank = '1;
		end
		new_row = ram_rdata;
		for (int v = 0; v < NW; v++) begin
			if ((WAY_W + 1)'(v) < ways && WAY_W'(v) != victim && ram_rdata.valid[v]
				&& {1'b0, ram_rdata.rank[v]} < old_rank
				&& {1'b0, ram_rdata.rank[v]} < (ways - (WAY_W + 1)'(1))) begin
				new_row.rank[v] = ram_rdata.rank[v] + RANK_W'(1);
			end
		end
		new_row.rank[victim] = '0;
		if (!hit_q) begin
			new_row.valid[victim] = 1'b1;
			new_row.tag[victim]   = tag_q;
		end
	end

	always_comb begin
		hits_nx   = hits_q;
		misses_nx = misses_q;
		if (hit_q) begin
			if (hits_q != '1) begin
				hits_nx = hits_q + CW'(1);
			end
		end else if (misses_q != '1) begin
			misses_nx = misses_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q   <= sactl_pkg::LFSR_SEED;
			hits_q   <= '0;
			misses_q <= '0;
		end else if (cmd.update) begin
			if (!hit_q && !found_q && random_q) begin
				lfsr_q <= lfsr_nx;
			end
			hits_q   <= hits_nx;
			misses_q <= misses_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			out_q <= {4'b0, misses_nx, hits_nx, 3'(victim), hit_q};
		end
	end

	always_comb begin
		ram_re    = cmd.accept;
		ram_we    = cmd.clear_wr || (cmd.update && do_touch);
		ram_wdata = cmd.clear_wr ? '0 : new_row;
		if (cmd.accept) begin
			ram_addr = set_full[SET_W-1:0];
		end else if (cmd.clear_wr) begin
			ram_addr = clr_cnt_q;
		end else begin
			ram_addr = set_q;
		end
	end

	assign m_tdata = out_q;

endmodule

// ----- dv/tb_set_assoc_cache_tag_lookup.sv -----
`timescale 1ns / 1ps

module tb_set_assoc_cache_tag_lookup;

	localparam int SET_BITS    = $clog2(sactl_pkg::DEF_MAX_SETS);
	localparam int LINES       = sactl_pkg::DEF_MAX_SETS * sactl_pkg::MAX_WAYS;
	localparam int CYCLE_LIMIT = 400000;
	localparam int CHUNK_ITEMS = 40;
	localparam int PHASE_CHUNKS = 6;

	typedef struct packed {
		logic                            hit;
		logic [sactl_pkg::WAY_W-1:0]     way;
		logic [sactl_pkg::CNT_W-1:0]     hits;
		logic [sactl_pkg::CNT_W-1:0]     misses;
	} lookup_t;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	logic [sactl_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [sactl_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [sactl_pkg::S_DATA_W-1:0]   s_tdata;
	logic                             m_tvalid;
	logic                             m_tready;
	logic [sactl_pkg::M_DATA_W-1:0]   m_tdata;

	// lookup model state
	bit                           line_ok [LINES];
	logic [sactl_pkg::TAG_W-1:0]  line_tag_q [LINES];
	logic [sactl_pkg::RANK_W-1:0] line_rank [LINES];
	logic [sactl_pkg::LFSR_W-1:0] victim_lfsr;
	logic [sactl_pkg::CNT_W-1:0]  hit_count;
	logic [sactl_pkg::CNT_W-1:0]  miss_count;
	logic [1:0]                   cur_ways_log2;
	logic [3:0]                   cur_offset;
	logic [2:0]                   cur_idx_width;
	logic                         cur_random;

	lookup_t lookup_q[$];
	int      mismatches = 0;
	int      cycle_count = 0;
	int      idle_pct;
	int      stall_pct;

	set_assoc_cache_tag_lookup #(
		.MAX_SETS(sactl_pkg::DEF_MAX_SETS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL set_assoc_cache_tag_lookup");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic int eff_ways();
		int w;
		w = 1 << cur_ways_log2;
		if (w > sactl_pkg::MAX_WAYS)
			w = sactl_pkg::MAX_WAYS;
		return w;
	endfunction

	function automatic int eff_idx_width();
		return (cur_idx_width > SET_BITS) ? SET_BITS : int'(cur_idx_width);
	endfunction

	function automatic void touch_way(int base, int ways, int w, bit was_valid);
		int old_rank;
		old_rank = was_valid ? int'(line_rank[base + w]) : 'hFFFF;
		for (int v = 0; v < ways; v++) begin
			if (v != w && line_ok[base + v] && int'(line_rank[base + v]) < old_rank &&
			    int'(line_rank[base + v]) < ways - 1)
				line_rank[base + v] = line_rank[base + v] + 1'b1;
		end
		line_rank[base + w] = '0;
	endfunction

	function automatic lookup_t predict_lookup(logic [31:0] addr);
		int           ib;
		int           ways;
		int           set_no;
		int           base;
		int           victim;
		logic [31:0]  tag;
		bit           hit;
		bit           found;
		lookup_t      r;
		ib = eff_idx_width();
		ways = eff_ways();
		set_no = int'((addr >> cur_offset) & ((32'd1 << ib) - 1)) % sactl_pkg::DEF_MAX_SETS;
		tag = addr >> (int'(cur_offset) + ib);
		base = set_no * sactl_pkg::MAX_WAYS;
		hit = 1'b0;
		found = 1'b0;
		victim = 0;
		for (int w = 0; w < ways && !hit; w++) begin
			if (line_ok[base + w] && line_tag_q[base + w] == tag) begin
				hit = 1'b1;
				victim = w;
			end
		end
		if (hit) begin
			if (!cur_random)
				touch_way(base, ways, victim, 1'b1);
			if (hit_count != '1)
				hit_count = hit_count + 1'b1;
		end else begin
			for (int w = 0; w < ways && !found; w++) begin
				if (!line_ok[base + w]) begin
					victim = w;
					found = 1'b1;
				end
			end
			if (!found) begin
				if (cur_random) begin
					victim_lfsr = {victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^
					               victim_lfsr[5], victim_lfsr[sactl_pkg::LFSR_W-1:1]};
					victim = int'(victim_lfsr) % ways;
				end else begin
					victim = 0;
					for (int w = 1; w < ways; w++)
						if (line_rank[base + w] > line_rank[base + victim])
							victim = w;
				end
			end
			touch_way(base, ways, victim, line_ok[base + victim]);
			line_ok[base + victim] = 1'b1;
			line_tag_q[base + victim] = tag;
			if (miss_count != '1)
				miss_count = miss_count + 1'b1;
		end
		r.hit = hit;
		r.way = victim[sactl_pkg::WAY_W-1:0];
		r.hits = hit_count;
		r.misses = miss_count;
		return r;
	endfunction

	always @(posedge clk) begin : check_lookups
		lookup_t want;
		lookup_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.hit = m_tdata[0];
			got.way = m_tdata[3:1];
			got.hits = m_tdata[35:4];
			got.misses = m_tdata[67:36];
			if (lookup_q.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %h", $time, got);
				mismatches++;
			end else begin
				want = lookup_q.pop_front();
				if (got.hit !== want.hit) begin
					$display("%0t: hit expected %0h actual %0h", $time, want.hit, got.hit);
					mismatches++;
				end
				if (got.way !== want.way) begin
					$display("%0t: way_used expected %0h actual %0h", $time, want.way, got.way);
					mismatches++;
				end
				if (got.hits !== want.hits) begin
					$display("%0t: hit_total expected %0h actual %0h", $time, want.hits,
					         got.hits);
					mismatches++;
				end
				if (got.misses !== want.misses) begin
					$display("%0t: miss_total expected %0h actual %0h", $time, want.misses,
					         got.misses);
					mismatches++;
				end
			end
		end
	end

	task automatic send_request(input logic [31:0] addr);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= addr;
		do
			@(posedge clk);
		while (!s_tready);
		lookup_q.push_back(predict_lookup(addr));
	endtask

	// hold the sender until every outstanding request has its result
	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		while (lookup_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input sactl_pkg::cfg_reg_t r, input logic [3:0] v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		case (r)
			sactl_pkg::REG_WAYS_LOG2:      cur_ways_log2 = v[1:0];
			sactl_pkg::REG_OFFSET_WIDTH:   cur_offset = v[3:0];
			sactl_pkg::REG_INDEX_WIDTH:    cur_idx_width = v[2:0];
			sactl_pkg::REG_RANDOM_REPLACE: cur_random = v[0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [3:0] ways_log2, input logic [3:0] off_width,
	                          input logic [3:0] idx_width, input logic [3:0] random_mode);
		wait_all_results();
		write_reg(sactl_pkg::REG_WAYS_LOG2, ways_log2);
		write_reg(sactl_pkg::REG_OFFSET_WIDTH, off_width);
		write_reg(sactl_pkg::REG_INDEX_WIDTH, idx_width);
		write_reg(sactl_pkg::REG_RANDOM_REPLACE, random_mode);
		cfg_we <= 1'b0;
	endtask

	// reset configuration: direct mapped, 4-byte lines, 16 sets
	task automatic test_direct_mapped_defaults();
		send_request(32'h0000_0000);
		send_request(32'h0000_0000);
		send_request(32'hFFFF_FFFF);
		send_request(32'hFFFF_FFFF);
		send_request(32'h0000_0040);
		send_request(32'h0000_0003);
	endtask

	task automatic test_lru_replacement();
		int order[8] = '{1, 2, 3, 4, 1, 5, 3, 6};
		set_config(4'd2, 4'd4, 4'd2, 4'd0);
		foreach (order[i])
			send_request((32'(order[i]) << 6) | 32'h10);
	endtask

	task automatic test_random_victims();
		int order[6] = '{7, 9, 7, 11, 13, 15};
		set_config(4'd1, 4'd0, 4'd0, 4'd1);
		foreach (order[i])
			send_request(32'(order[i]));
	endtask

	// upper bits of wide writes are dropped; index width beyond the sets saturates
	task automatic test_register_extremes();
		set_config(4'hF, 4'hF, 4'hF, 4'hE);
		send_request(32'hFFFF_FFFF);
		send_request(32'h0000_0000);
		send_request(32'hFFFF_FFFF);
		set_config(4'h0, 4'h0, 4'h0, 4'h0);
		send_request(32'h1234_5678);
		send_request(32'h1234_5678);
	endtask

	function automatic logic [31:0] make_address();
		int          ib;
		int          off;
		logic [31:0] tag;
		logic [31:0] set_no;
		if ($urandom_range(9) < 2)
			return $urandom();
		ib = eff_idx_width();
		off = int'(cur_offset);
		tag = $urandom_range(2 * eff_ways() + 1);
		set_no = $urandom_range(3) & ((32'd1 << ib) - 1);
		return (tag << (off + ib)) | (set_no << off) | ($urandom() & ((32'd1 << off) - 1));
	endfunction

	task automatic test_random_traffic(input int sender_idle, input int receiver_stall);
		idle_pct = sender_idle;
		stall_pct = receiver_stall;
		for (int c = 0; c < PHASE_CHUNKS; c++) begin
			if (c == 0)
				set_config(4'h3, 4'hF, 4'h7, 4'h1);
			else if (c == 1)
				set_config(4'h0, 4'h0, 4'h0, 4'h0);
			else
				set_config(4'($urandom_range(3)), 4'($urandom_range(15)),
				           4'($urandom_range(7)), 4'($urandom_range(1)));
			repeat (CHUNK_ITEMS)
				send_request(make_address());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = sactl_pkg::REG_WAYS_LOG2;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		idle_pct = 0;
		stall_pct = 0;
		foreach (line_rank[i]) begin
			line_ok[i] = 1'b0;
			line_rank[i] = '0;
			line_tag_q[i] = '0;
		end
		victim_lfsr = sactl_pkg::LFSR_SEED;
		hit_count = '0;
		miss_count = '0;
		cur_ways_log2 = 2'd0;
		cur_offset = 4'd2;
		cur_idx_width = 3'd4;
		cur_random = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_direct_mapped_defaults();
		test_lru_replacement();
		test_random_victims();
		test_register_extremes();
		test_random_traffic(0, 0);
		test_random_traffic(55, 0);
		test_random_traffic(0, 55);
		test_random_traffic(38, 38);

		wait_all_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("PASS set_assoc_cache_tag_lookup");
		else
			$display("FAIL set_assoc_cache_tag_lookup");
		$finish;
	end

endmodule

// ----- files.f -----
design/sactl_pkg.sv
design/sactl_ram.sv
design/sactl_ctrl.sv
design/sactl_dpath.sv
design/set_assoc_cache_tag_lookup.sv
dv/tb_set_assoc_cache_tag_lookup.sv
